/* rtl/dpvb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvb_pkg
// Shared constants and types for the plan-view disparity binning block.
// ----------------------------------------------------------------------------
package dpvb_pkg;
  localparam int GRID_CELLS = 80;
  localparam int IMAGE_DIM  = 1024;
  localparam int NCELLS     = GRID_CELLS * GRID_CELLS;
  localparam int AW         = $clog2(NCELLS);
  localparam int CW         = 7;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_BIN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_CX   = 3'd0,
    CFG_CY   = 3'd1,
    CFG_FOC  = 3'd2,
    CFG_IB   = 3'd3,
    CFG_COS  = 3'd4,
    CFG_SIN  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] foc;
    logic [15:0] ib;
    logic [15:0] cs;
    logic [15:0] sn;
  } cfg_t;

  // projection result handed to the grid side
  typedef struct packed {
    logic          ok;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic [31:0]   add;
  } proj_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_PROJ, ST_RD, ST_WB, ST_DONE
  } state_t;

  // projection unit sequencing
  typedef enum logic [2:0] {P_IDLE, P_MUL, P_SUM, P_CHK, P_DIV} pst_t;

  localparam logic [5:0] DIV_STEPS = 6'd33;
endpackage

/* rtl/dpvb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvb_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dpvb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/dpvb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvb_div
// Restoring divider, one quotient bit per cycle, unsigned 64 / 48.
// Quotient is limited to 33 bits; callers only need small quotients.
// ----------------------------------------------------------------------------
module dpvb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [32:0] quo
);
  import dpvb_pkg::*;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [32:0] q_r, q_nxt, q_step;
  logic [47:0] den_r, den_nxt;
  logic [96:0] trial;
  logic        run_r, run_nxt;

  always_comb begin
    cnt_nxt = cnt_r; rem_nxt = rem_r; q_nxt = q_r; den_nxt = den_r; run_nxt = run_r;
    done = run_r && (cnt_r == 6'd0);
    trial = {33'd0, rem_r} - ({49'd0, den_r} << cnt_r);
    q_step = trial[96] ? q_r : (q_r | (33'd1 << cnt_r));
    if (run_r) begin
      if (!trial[96]) rem_nxt = trial[63:0];
      q_nxt = q_step;
      if (cnt_r == 6'd0) run_nxt = 1'b0;
      else cnt_nxt = cnt_r - 6'd1;
    end
    // a new division may load on the done cycle
    if (go) begin
      rem_nxt = num; den_nxt = den; q_nxt = '0; cnt_nxt = DIV_STEPS - 6'd1; run_nxt = 1'b1;
    end
  end
  assign quo = q_step;

  always_ff @(posedge clk) begin
    if (!rst_n) run_r <= 1'b0;
    else run_r <= run_nxt;
    cnt_r <= cnt_nxt; rem_r <= rem_nxt; q_r <= q_nxt; den_r <= den_nxt;
  end
endmodule

/* rtl/dpvb_proj.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvb_proj
// Reprojects one disparity pixel, checks the grid window and height band,
// and finds cell indices and depth addend with one shared divider.
// ----------------------------------------------------------------------------
module dpvb_proj (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  dpvb_pkg::cfg_t         cfg,
  input  logic [9:0]             row,
  input  logic [9:0]             col,
  input  logic [15:0]            disp,
  output logic                   done,
  output dpvb_pkg::proj_t        res
);
  import dpvb_pkg::*;
  pst_t          st_r, st_nxt;
  logic [1:0]    dk_r, dk_nxt;
  logic signed [17:0] nx_r, ny_r;
  logic signed [35:0] sny_r, cf_r, cny_r, sf_r;
  logic [31:0]   ibd_r;
  logic [47:0]   den_r;
  logic signed [63:0] xv_r, zv_r, zn_r, yn_r;
  logic [63:0]   lim;
  logic          pre_ok_r, ok_nxt, ok_r;
  logic [32:0]   qx_r, qz_r, qa_r, quo;
  logic          dgo, ddone;
  logic [63:0]   dnum;
  logic signed [63:0] den_s;

  assign lim   = 64'(GRID_CELLS) * {16'd0, den_r};
  assign den_s = {16'd0, den_r};

  dpvb_div u_div (.clk, .rst_n, .go(dgo), .num(dnum), .den(den_r), .done(ddone), .quo);

  always_comb begin
    st_nxt = st_r; dk_nxt = dk_r; ok_nxt = ok_r; dgo = 1'b0; dnum = '0; done = 1'b0;
    unique case (st_r)
      P_IDLE: if (go) st_nxt = P_MUL;
      P_MUL:  st_nxt = P_SUM;
      P_SUM:  st_nxt = P_CHK;
      P_CHK: begin
        ok_nxt = pre_ok_r
          && (xv_r >= den_s) && (xv_r < $signed(lim))
          && (zv_r >= den_s) && (zv_r < $signed(lim))
          && (20 * yn_r > -den_s) && (yn_r < den_s);
        if (ok_nxt) begin
          dgo = 1'b1; dnum = xv_r; dk_nxt = 2'd0; st_nxt = P_DIV;
        end else begin
          done = 1'b1; st_nxt = P_IDLE;
        end
      end
      P_DIV: if (ddone) begin
        unique case (dk_r)
          2'd0: begin dgo = 1'b1; dnum = zv_r; dk_nxt = 2'd1; end
          2'd1: begin dgo = 1'b1; dnum = zn_r <<< 8; dk_nxt = 2'd2; end
          default: begin done = 1'b1; st_nxt = P_IDLE; end
        endcase
      end
      default: st_nxt = P_IDLE;
    endcase
  end

  // ok is taken on the done cycle, so a reject shows it right away
  assign res = '{ok: ok_nxt, row: qz_r[CW-1:0], col: qx_r[CW-1:0], add: qa_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    dk_r <= dk_nxt; ok_r <= ok_nxt;
    if (ddone && dk_r == 2'd0) qx_r <= quo;
    if (ddone && dk_r == 2'd1) qz_r <= quo;
    if (ddone && dk_r == 2'd2) qa_r <= quo;
    if (go) begin
      nx_r <= 18'(signed'({1'b0, col, 4'd0})) + 18'(signed'(cfg.cx));
      ny_r <= 18'(signed'({1'b0, row, 4'd0})) + 18'(signed'(cfg.cy));
      ibd_r <= cfg.ib * disp;
      pre_ok_r <= (disp > 16'd8) && (cfg.ib != 16'd0)
                  && ({1'b0, row} < 11'(IMAGE_DIM)) && ({1'b0, col} < 11'(IMAGE_DIM));
    end
    if (st_r == P_MUL) begin
      den_r <= {2'd0, ibd_r, 14'd0};
      sny_r <= $signed(cfg.sn) * ny_r;
      cny_r <= $signed(cfg.cs) * ny_r;
      cf_r  <= $signed(cfg.cs) * $signed({1'b0, cfg.foc});
      sf_r  <= $signed(cfg.sn) * $signed({1'b0, cfg.foc});
    end
    if (st_r == P_SUM) begin
      xv_r <= (64'(nx_r) <<< 26) + 64'(40) * den_s;
      zn_r <= (64'(sny_r) + 64'(cf_r)) <<< 8;
      zv_r <= (64'(sny_r) + 64'(cf_r)) <<< 12;
      yn_r <= (64'(cny_r) - 64'(sf_r)) <<< 8;
    end
  end
endmodule

/* rtl/disparity_plan_view_binning.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_plan_view_binning
// Plan-view occupancy grid built from stereo disparity pixels.
// Request flow: a read does one RAM read; a pixel is rejected after projection or
//   binned (three 33-step divisions on one shared divider, then grid RMW).
// Clear: one cell per cycle over the whole grid. One request at a time; busy is high
//   from acceptance until the result strobe, when the next word can be taken.
// Reset: synchronous; a clearing pass over every cell runs with busy high, no result.
// ----------------------------------------------------------------------------
module disparity_plan_view_binning (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [9:0]  in_pixel_row,
  input  logic [9:0]  in_pixel_col,
  input  logic [15:0] in_disparity,
  input  logic [6:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  output logic        out_binned,
  output logic [6:0]  out_bin_row,
  output logic [6:0]  out_bin_col,
  output logic [31:0] out_cell_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dpvb_pkg::*;
  state_t      st_r, st_nxt;
  cfg_t        cfg_r;
  logic [AW-1:0] addr_r, addr_nxt, ram_addr;
  logic        we;
  logic [31:0] wdata, rdata;
  logic [1:0]  kind_r;
  logic        rd_ok_r;
  logic        pgo, pdone;
  proj_t       pres;
  logic [32:0] sum;
  logic        v_nxt, b_nxt;
  logic [6:0]  r_nxt, c_nxt;
  logic [31:0] cv_nxt;

  assign cfg_ready = 1'b1;
  assign busy = (st_r != ST_IDLE);

  dpvb_ram #(.WIDTH(32), .DEPTH(NCELLS)) u_ram (
    .clk, .we, .addr(ram_addr), .wdata, .rdata);

  dpvb_proj u_proj (.clk, .rst_n, .go(pgo), .cfg(cfg_r), .row(in_pixel_row),
    .col(in_pixel_col), .disp(in_disparity), .done(pdone), .res(pres));

  assign sum = {1'b0, rdata} + {1'b0, pres.add};

  always_comb begin
    st_nxt = st_r; addr_nxt = addr_r; we = 1'b0; wdata = '0; ram_addr = addr_r;
    pgo = 1'b0; v_nxt = 1'b0; b_nxt = 1'b0; r_nxt = '0; c_nxt = '0; cv_nxt = '0;
    unique case (st_r)
      ST_IDLE: if (start) begin
        unique case (in_req_type)
          REQ_CLEAR: begin addr_nxt = '0; st_nxt = ST_CLEAR; end
          REQ_BIN:   begin pgo = 1'b1; st_nxt = ST_PROJ; end
          REQ_READ: begin
            addr_nxt = AW'(in_read_row * GRID_CELLS) + AW'(in_read_col);
            st_nxt = ST_RD;
          end
          default: st_nxt = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        we = 1'b1;
        // the clearing pass after reset ends without a result word
        if (addr_r == AW'(NCELLS - 1)) st_nxt = (kind_r == REQ_CLEAR) ? ST_DONE : ST_IDLE;
        else addr_nxt = addr_r + AW'(1);
      end
      ST_PROJ: if (pdone) begin
        if (pres.ok) begin
          addr_nxt = AW'(pres.row * GRID_CELLS) + AW'(pres.col);
          ram_addr = addr_nxt;
          st_nxt = ST_RD;
        end else st_nxt = ST_DONE;
      end
      ST_RD: st_nxt = (kind_r == REQ_BIN) ? ST_WB : ST_DONE;
      ST_WB: begin
        we = 1'b1;
        wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        v_nxt = 1'b1; b_nxt = 1'b1; r_nxt = pres.row; c_nxt = pres.col;
        st_nxt = ST_IDLE;
      end
      ST_DONE: begin
        v_nxt = 1'b1;
        if (kind_r == REQ_READ && rd_ok_r) cv_nxt = rdata;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_IDLE) ram_addr = addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;   // reset sweeps the grid to zero
      addr_r <= '0;
      kind_r <= REQ_NONE;
      out_valid <= 1'b0;
      cfg_r <= '{cx: 16'hEC08, cy: 16'hF108, foc: 16'd8400, ib: 16'd3413,
                 cs: 16'd16384, sn: 16'd0};
    end else begin
      st_r <= st_nxt;
      addr_r <= addr_nxt;
      out_valid <= v_nxt;
      if (st_r == ST_IDLE && start) kind_r <= in_req_type;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CX:  cfg_r.cx  <= cfg_data;
          CFG_CY:  cfg_r.cy  <= cfg_data;
          CFG_FOC: cfg_r.foc <= cfg_data;
          CFG_IB:  cfg_r.ib  <= cfg_data;
          CFG_COS: cfg_r.cs  <= cfg_data;
          CFG_SIN: cfg_r.sn  <= cfg_data;
          default: ;
        endcase
      end
    end
    if (st_r == ST_IDLE && start)
      rd_ok_r <= (in_read_row < 7'(GRID_CELLS)) && (in_read_col < 7'(GRID_CELLS));
    out_binned <= b_nxt; out_bin_row <= r_nxt; out_bin_col <= c_nxt;
    out_cell_value <= cv_nxt;
  end
endmodule

/* rtl/dpvb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvb_checker
// Port-level checks for the plan-view binning block.
// ----------------------------------------------------------------------------
module dpvb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_binned,
  input logic [6:0]  out_bin_row,
  input logic [6:0]  out_bin_col,
  input logic [31:0] out_cell_value
);
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("back-to-back strobes");
  a_nobin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_binned) |-> (out_bin_row == 7'd0 && out_bin_col == 7'd0))
    else $error("cell index without binned");
  a_bin_noval: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_binned) |-> (out_cell_value == 32'd0 && out_bin_row < 7'd80))
    else $error("bad binned result");
endmodule

bind disparity_plan_view_binning dpvb_checker u_chk (.*);
